FILE: rtl/core/hnb_pkg.sv
// hnb_pkg: shared types, constants and helpers of the histogram naive bayes classifier
// used by hnb_front, hnb_log2, hnb_back and the top level; no dependencies

package hnb_pkg;

	localparam int MAX_CLASSES_DEF  = 16;
	localparam int MAX_FEATURES_DEF = 64;
	localparam int MAX_BINS_DEF     = 256;

	// fixed field widths
	localparam int KIND_W  = 3;
	localparam int CLS_F_W = 4;
	localparam int FEAT_F_W = 6;
	localparam int BIN_F_W = 8;
	localparam int VAL_W   = 32;
	localparam int CNT_W   = 16;
	localparam int LOGN_W  = 17;
	localparam int LOGR_W  = 21;

	// input kinds
	localparam logic [KIND_W-1:0] KIND_CLASS_COUNT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_EDGE        = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FREQ        = 3'd2;
	localparam logic [KIND_W-1:0] KIND_EDGE_COUNT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLASSIFY    = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_NUM_CLASSES  = 2'd0;
	localparam logic [1:0] CFG_NUM_FEATURES = 2'd1;
	localparam logic [1:0] CFG_TRAIN_COUNT  = 2'd2;
	localparam logic [1:0] CFG_SMOOTHING    = 2'd3;

	typedef enum logic [2:0] {
		OP_CLASS_COUNT,
		OP_EDGE,
		OP_FREQ,
		OP_EDGE_COUNT,
		OP_CLASSIFY
	} op_t;

	typedef struct packed {
		op_t                   op;
		logic [CLS_F_W-1:0]    cls;
		logic [FEAT_F_W-1:0]   feat;
		logic [BIN_F_W-1:0]    bin;
		logic signed [VAL_W-1:0] value;
		logic [CNT_W-1:0]      count;
		logic                  last;
	} cmd_t;

	typedef struct packed {
		logic [4:0]  num_classes;
		logic [6:0]  num_features;
		logic [15:0] training_count;
		logic [15:0] smoothing_extra;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [LOGN_W-1:0] n;
	} log_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [LOGR_W-1:0] result;
	} log_rsp_t;

	typedef struct packed {
		logic                    impossible;
		logic signed [VAL_W-1:0] score;
		logic [CLS_F_W-1:0]      cls;
	} result_t;

	// score + a - b, saturated to the signed 32-bit range
	function automatic logic signed [VAL_W-1:0] sat_add(
		input logic signed [VAL_W-1:0] score,
		input logic [LOGR_W-1:0] a,
		input logic [LOGR_W-1:0] b
	);
		logic signed [VAL_W+1:0] s;
		logic signed [VAL_W-1:0] r;
		s = {{2{score[VAL_W-1]}}, score} + $signed({13'd0, a}) - $signed({13'd0, b});
		if (s[VAL_W+1:VAL_W-1] == 3'b000 || s[VAL_W+1:VAL_W-1] == 3'b111) begin
			r = s[VAL_W-1:0];
		end else if (s[VAL_W+1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/hnb_front.sv
// hnb_front: accepts input beats, decodes the kind, drops ignored items
// and queues commands for the back end; depends on hnb_pkg

module hnb_front #(
	parameter int MAX_CLASSES  = hnb_pkg::MAX_CLASSES_DEF,
	parameter int MAX_FEATURES = hnb_pkg::MAX_FEATURES_DEF,
	parameter int MAX_BINS     = hnb_pkg::MAX_BINS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hnb_pkg::cmd_t       in_item,
	input  logic [2:0]          in_kind,
	output logic                q_valid,
	output hnb_pkg::cmd_t       q_cmd,
	input  logic                q_pop
);
	import hnb_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       dec;
	logic       keep;
	logic       push;

	always_comb begin
		dec  = in_item;
		keep = 1'b0;
		case (in_kind)
			KIND_CLASS_COUNT: begin
				dec.op = OP_CLASS_COUNT;
				keep   = 32'(in_item.cls) < MAX_CLASSES;
			end
			KIND_EDGE: begin
				dec.op = OP_EDGE;
				keep   = 32'(in_item.feat) < MAX_FEATURES && 32'(in_item.bin) < MAX_BINS - 1;
			end
			KIND_FREQ: begin
				dec.op = OP_FREQ;
				keep   = 32'(in_item.cls) < MAX_CLASSES && 32'(in_item.feat) < MAX_FEATURES
					&& 32'(in_item.bin) < MAX_BINS;
			end
			KIND_EDGE_COUNT: begin
				dec.op = OP_EDGE_COUNT;
				keep   = 32'(in_item.feat) < MAX_FEATURES;
				if (32'(in_item.count) > MAX_BINS - 1) begin
					dec.count = CNT_W'(MAX_BINS - 1);
				end
			end
			KIND_CLASSIFY: begin
				dec.op = OP_CLASSIFY;
				keep   = 1'b1;
			end
			default: begin
				dec.op = OP_CLASSIFY;
				keep   = 1'b0;
			end
		endcase
	end

	assign in_ready = cnt_q != 2'd2;
	assign push     = in_valid && in_ready && keep;
	assign q_valid  = cnt_q != 2'd0;
	assign q_cmd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

FILE: rtl/core/hnb_log2.sv
// hnb_log2: iterative log2 in q.16, one squaring step per cycle
// depends on hnb_pkg

module hnb_log2 (
	input  logic              clk,
	input  logic              arst_n,
	input  hnb_pkg::log_req_t req,
	output hnb_pkg::log_rsp_t rsp
);
	import hnb_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [3:0]        step_q;
	logic [LOGN_W-1:0] m_q;
	logic [4:0]        e_q;
	logic [15:0]       frac_q;
	logic [4:0]        e_d;
	logic [LOGN_W-1:0] n_eff;
	logic [2*LOGN_W-1:0] sq;
	logic [LOGN_W:0]   t;

	always_comb begin
		n_eff = (req.n == '0) ? LOGN_W'(1) : req.n;
		e_d   = 5'd0;
		for (int i = 0; i < LOGN_W; i++) begin
			if (n_eff[i]) begin
				e_d = 5'(i);
			end
		end
		sq = m_q * m_q;
		t  = sq[2*LOGN_W-1:16];
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			m_q    <= n_eff << (5'd16 - e_d);
			e_q    <= e_d;
			frac_q <= '0;
		end else if (busy_q) begin
			if (t[LOGN_W]) begin
				m_q            <= t[LOGN_W:1];
				frac_q[step_q] <= 1'b1;
			end else begin
				m_q <= t[LOGN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= 4'd15;
			end else if (busy_q) begin
				step_q <= step_q - 4'd1;
				if (step_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = {e_q, frac_q};

endmodule

FILE: rtl/core/hnb_back.sv
// hnb_back: table memories, bin search, per-class score update and argmax
// sequencer with the result register; depends on hnb_pkg, drives hnb_log2

module hnb_back #(
	parameter int MAX_CLASSES  = hnb_pkg::MAX_CLASSES_DEF,
	parameter int MAX_FEATURES = hnb_pkg::MAX_FEATURES_DEF,
	parameter int MAX_BINS     = hnb_pkg::MAX_BINS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hnb_pkg::cfg_t      cfg,
	input  logic               q_valid,
	input  hnb_pkg::cmd_t      q_cmd,
	output logic               q_pop,
	output hnb_pkg::log_req_t  log_req,
	input  hnb_pkg::log_rsp_t  log_rsp,
	output logic               res_valid,
	input  logic               res_ready,
	output hnb_pkg::result_t   res
);
	import hnb_pkg::*;

	localparam int CLS_W  = $clog2(MAX_CLASSES);
	localparam int FEAT_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int BIN_W  = $clog2(MAX_BINS);
	localparam int KCNT_W = $clog2(MAX_CLASSES + 1);
	localparam int FCNT_W = $clog2(MAX_FEATURES + 1);
	localparam int EDGE_DEPTH = 2 ** (FEAT_W + BIN_W);
	localparam int FREQ_DEPTH = 2 ** (CLS_W + FEAT_W + BIN_W);

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_EC   = 12'b000000000010,
		ST_SRCH = 12'b000000000100,
		ST_CLS  = 12'b000000001000,
		ST_FRD  = 12'b000000010000,
		ST_LA   = 12'b000000100000,
		ST_LB   = 12'b000001000000,
		ST_PRI  = 12'b000010000000,
		ST_PA   = 12'b000100000000,
		ST_PB   = 12'b001000000000,
		ST_OUT  = 12'b010000000000,
		ST_NEXT = 12'b100000000000
	} st_t;

	st_t                      st_q;
	logic signed [VAL_W-1:0]  value_q;
	logic                     last_q;
	logic [FEAT_W-1:0]        pos_q;
	logic [BIN_W-1:0]         ec_mem [MAX_FEATURES];
	logic [MAX_FEATURES-1:0]  ec_vld_q;
	logic [BIN_W-1:0]         ec_rd_q;
	logic [BIN_W-1:0]         ec_q;
	logic [VAL_W-1:0]         edge_mem [EDGE_DEPTH];
	logic [VAL_W-1:0]         edge_rd_q;
	logic [CNT_W-1:0]         freq_mem [FREQ_DEPTH];
	logic [CNT_W-1:0]         freq_rd_q;
	logic [BIN_W-1:0]         idx_q;
	logic                     pend_q;
	logic [BIN_W-1:0]         bin_q;
	logic [KCNT_W-1:0]        k_q;
	logic [CNT_W-1:0]         cc_q [MAX_CLASSES];
	logic signed [VAL_W-1:0]  score_q [MAX_CLASSES];
	logic [MAX_CLASSES-1:0]   dead_q;
	logic [LOGR_W-1:0]        la_q;
	logic signed [VAL_W-1:0]  best_q;
	logic [CLS_W-1:0]         win_q;
	logic                     any_q;
	logic                     log_start_q;
	logic [LOGN_W-1:0]        log_n_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [CLS_W-1:0]         k_idx;
	logic [KCNT_W-1:0]        nc;
	logic [FCNT_W-1:0]        nf;
	logic                     pat_end;
	logic                     issue;
	logic                     load_pop;
	logic signed [VAL_W-1:0]  upd;
	logic [CNT_W-1:0]         cc_k;
	logic [CNT_W-1:0]         tc;

	always_comb begin
		k_idx = k_q[CLS_W-1:0];
		cc_k  = cc_q[k_idx];
		tc    = (cfg.training_count == '0) ? CNT_W'(1) : cfg.training_count;
		if (cfg.num_classes == '0) begin
			nc = KCNT_W'(1);
		end else if (32'(cfg.num_classes) > MAX_CLASSES) begin
			nc = KCNT_W'(MAX_CLASSES);
		end else begin
			nc = KCNT_W'(cfg.num_classes);
		end
		if (cfg.num_features == '0) begin
			nf = FCNT_W'(1);
		end else if (32'(cfg.num_features) > MAX_FEATURES) begin
			nf = FCNT_W'(MAX_FEATURES);
		end else begin
			nf = FCNT_W'(cfg.num_features);
		end
		pat_end  = last_q || (FCNT_W'(pos_q) + FCNT_W'(1) >= nf);
		issue    = (st_q == ST_SRCH) && (idx_q < ec_q);
		q_pop    = (st_q == ST_IDLE) && q_valid;
		load_pop = q_pop && (q_cmd.op != OP_CLASSIFY);
		upd      = sat_add(score_q[k_idx], la_q, log_rsp.result);
	end

	// table memories
	always_ff @(posedge clk) begin
		if (load_pop && q_cmd.op == OP_EDGE_COUNT) begin
			ec_mem[FEAT_W'(q_cmd.feat)] <= BIN_W'(q_cmd.count);
		end
		ec_rd_q <= ec_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (load_pop && q_cmd.op == OP_EDGE) begin
			edge_mem[{FEAT_W'(q_cmd.feat), BIN_W'(q_cmd.bin)}] <= q_cmd.value;
		end
		edge_rd_q <= edge_mem[{pos_q, idx_q}];
	end

	always_ff @(posedge clk) begin
		if (load_pop && q_cmd.op == OP_FREQ) begin
			freq_mem[{CLS_W'(q_cmd.cls), FEAT_W'(q_cmd.feat), BIN_W'(q_cmd.bin)}] <= q_cmd.count;
		end
		freq_rd_q <= freq_mem[{k_idx, pos_q, bin_q}];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			value_q <= q_cmd.value;
			last_q  <= q_cmd.last;
		end
		if (st_q == ST_EC) begin
			ec_q <= ec_vld_q[pos_q] ? ec_rd_q : '0;
		end
		if ((st_q == ST_LA || st_q == ST_PA) && log_rsp.done) begin
			la_q <= log_rsp.result;
		end
		case (st_q)
			ST_FRD:  log_n_q <= LOGN_W'(freq_rd_q) + LOGN_W'(1);
			ST_LA:   log_n_q <= LOGN_W'(cc_k) + LOGN_W'(cfg.smoothing_extra);
			ST_PRI:  log_n_q <= LOGN_W'(cc_k);
			ST_PA:   log_n_q <= LOGN_W'(tc);
			default: log_n_q <= log_n_q;
		endcase
		if (st_q == ST_OUT && (!out_valid_q || res_ready)) begin
			out_q.cls        <= CLS_F_W'(win_q);
			out_q.score      <= any_q ? best_q : {1'b1, {(VAL_W-1){1'b0}}};
			out_q.impossible <= !any_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pos_q       <= '0;
			ec_vld_q    <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			bin_q       <= '0;
			k_q         <= '0;
			dead_q      <= '0;
			best_q      <= '0;
			win_q       <= '0;
			any_q       <= 1'b0;
			log_start_q <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_CLASSES; i++) begin
				cc_q[i]    <= '0;
				score_q[i] <= '0;
			end
		end else begin
			log_start_q <= 1'b0;
			if (out_valid_q && res_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						case (q_cmd.op)
							OP_CLASS_COUNT: cc_q[CLS_W'(q_cmd.cls)] <= q_cmd.count;
							OP_EDGE_COUNT:  ec_vld_q[FEAT_W'(q_cmd.feat)] <= 1'b1;
							OP_CLASSIFY:    st_q <= ST_EC;
							default:        st_q <= ST_IDLE;
						endcase
					end
				end
				ST_EC: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					bin_q  <= '0;
					st_q   <= ST_SRCH;
				end
				ST_SRCH: begin
					// one edge read per cycle, compared when its data returns
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + BIN_W'(1);
					end
					if (pend_q && $signed(edge_rd_q) <= value_q) begin
						bin_q <= bin_q + BIN_W'(1);
					end
					if (!issue && !pend_q) begin
						k_q  <= '0;
						st_q <= ST_CLS;
					end
				end
				ST_CLS: begin
					if (k_q == nc) begin
						k_q   <= '0;
						any_q <= 1'b0;
						win_q <= '0;
						best_q <= {1'b1, {(VAL_W-1){1'b0}}};
						st_q  <= pat_end ? ST_PRI : ST_NEXT;
					end else if (cc_k == '0) begin
						dead_q[k_idx] <= 1'b1;
						k_q <= k_q + KCNT_W'(1);
					end else begin
						st_q <= ST_FRD;
					end
				end
				ST_FRD: begin
					log_start_q <= 1'b1;
					st_q <= ST_LA;
				end
				ST_LA: begin
					if (log_rsp.done) begin
						log_start_q <= 1'b1;
						st_q <= ST_LB;
					end
				end
				ST_LB: begin
					if (log_rsp.done) begin
						score_q[k_idx] <= upd;
						k_q  <= k_q + KCNT_W'(1);
						st_q <= ST_CLS;
					end
				end
				ST_PRI: begin
					if (k_q == nc) begin
						st_q <= ST_OUT;
					end else if (cc_k == '0 || dead_q[k_idx]) begin
						k_q <= k_q + KCNT_W'(1);
					end else begin
						log_start_q <= 1'b1;
						st_q <= ST_PA;
					end
				end
				ST_PA: begin
					if (log_rsp.done) begin
						log_start_q <= 1'b1;
						st_q <= ST_PB;
					end
				end
				ST_PB: begin
					if (log_rsp.done) begin
						if (!any_q || upd >= best_q) begin
							best_q <= upd;
							win_q  <= k_idx;
							any_q  <= 1'b1;
						end
						k_q  <= k_q + KCNT_W'(1);
						st_q <= ST_PRI;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || res_ready) begin
						out_valid_q <= 1'b1;
						pos_q  <= '0;
						dead_q <= '0;
						for (int i = 0; i < MAX_CLASSES; i++) begin
							score_q[i] <= '0;
						end
						st_q <= ST_IDLE;
					end
				end
				ST_NEXT: begin
					pos_q <= pos_q + FEAT_W'(1);
					st_q  <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign log_req.start = log_start_q;
	assign log_req.n     = log_n_q;
	assign res_valid     = out_valid_q;
	assign res           = out_q;

endmodule

FILE: rtl/core/histogram_naive_bayes_classifier.sv
// histogram_naive_bayes_classifier: top level of the histogram naive bayes classifier
// depends on hnb_pkg, hnb_front, hnb_log2, hnb_back
//
// channel | signals                            | beat
// s       | s_tvalid s_tready s_tdata s_tuser s_tlast | load or classify item
// m       | m_tvalid m_tready m_tdata m_tuser  | one result per finished pattern
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | one register write
//
// a load beat is stored while the back end stays idle; a classify beat reads the
// edge count, searches the edges and, per live class, reads a frequency and runs
// the log2 unit (start, 16 squaring steps and done) twice, which sets the pace;
// a pattern end adds two log2 runs per live class for the prior and the argmax
// reset clears counts, edge counts, scores and the queue; tables keep no reset
// a two-entry queue parts the front from the back, and a result register lets
// the back start the next item while a result waits on m_tready

module histogram_naive_bayes_classifier #(
	parameter int MAX_CLASSES  = hnb_pkg::MAX_CLASSES_DEF,
	parameter int MAX_FEATURES = hnb_pkg::MAX_FEATURES_DEF,
	parameter int MAX_BINS     = hnb_pkg::MAX_BINS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // class_index, feature_index, bin_index, value, count, zeros
	input  logic [2:0]  s_tuser,   // kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // predicted_class, best_score, zeros
	output logic        m_tuser,   // all_impossible
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import hnb_pkg::*;

	cfg_t     cfg_q;
	cmd_t     in_item;
	logic     q_valid;
	cmd_t     q_cmd;
	logic     q_pop;
	log_req_t log_req;
	log_rsp_t log_rsp;
	result_t  res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_classes     <= 5'd2;
			cfg_q.num_features    <= 7'd1;
			cfg_q.training_count  <= 16'd1;
			cfg_q.smoothing_extra <= 16'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_NUM_CLASSES:  cfg_q.num_classes     <= cfg_data[4:0];
				CFG_NUM_FEATURES: cfg_q.num_features    <= cfg_data[6:0];
				CFG_TRAIN_COUNT:  cfg_q.training_count  <= cfg_data;
				CFG_SMOOTHING:    cfg_q.smoothing_extra <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// unpack the input beat
	always_comb begin
		in_item.op    = OP_CLASSIFY;
		in_item.cls   = s_tdata[3:0];
		in_item.feat  = s_tdata[9:4];
		in_item.bin   = s_tdata[17:10];
		in_item.value = s_tdata[49:18];
		in_item.count = s_tdata[65:50];
		in_item.last  = s_tlast;
	end

	hnb_front #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_FEATURES(MAX_FEATURES),
		.MAX_BINS    (MAX_BINS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_item (in_item),
		.in_kind (s_tuser),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop)
	);

	hnb_log2 u_log2 (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (log_req),
		.rsp   (log_rsp)
	);

	hnb_back #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_FEATURES(MAX_FEATURES),
		.MAX_BINS    (MAX_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.log_req  (log_req),
		.log_rsp  (log_rsp),
		.res_valid(m_tvalid),
		.res_ready(m_tready),
		.res      (res)
	);

	// pack the result beat
	assign m_tdata = {4'd0, res.score, res.cls};
	assign m_tuser = res.impossible;

`ifndef NO_ASSERTIONS
	// an impossible pattern reports class 0 with the minimum score
	a_impossible_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[3:0] == 4'd0 && m_tdata[35:4] == 32'h80000000)
		else $error("impossible result carries wrong class or score");

	// the back end only pops a queue that holds a command
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// the log unit is never restarted while it iterates
	a_log_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		log_req.start |-> !log_rsp.busy)
		else $error("log2 unit started while busy");
`endif

endmodule

FILE: sim/histogram_naive_bayes_classifier_test.sv
// histogram_naive_bayes_classifier_test: self-checking bench for the histogram naive bayes classifier
// drives load and classify beats, writes the registers between phases and checks every result
// depends on hnb_pkg and histogram_naive_bayes_classifier
`timescale 1ns / 1ps

module histogram_naive_bayes_classifier_test;
	import hnb_pkg::*;

	localparam int N_CLASSES   = 16;
	localparam int N_FEATURES  = 64;
	localparam int N_BINS      = 256;
	localparam int EDGE_SLOTS  = N_BINS - 1;
	localparam int ITEM_TARGET = 850;
	localparam int QUIET_AFTER = 720;
	localparam int DRAIN_WAIT  = 5000;      // cycles a result-free classify beat may still run
	localparam int LONG_HOLD   = 6000;
	localparam longint CYCLE_LIMIT = 8000000;
	localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd5;   // kinds from here up are ignored

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [3:0]            cls;
		logic [5:0]            feat;
		logic [7:0]            bin;
		logic signed [31:0]    value;
		logic [15:0]           count;
		logic                  last;
	} beat_t;

	typedef struct {
		logic [3:0]         cls;
		logic signed [31:0] score;
		logic               impossible;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;   // class_index, feature_index, bin_index, value, count, zeros
	logic [2:0]  s_tuser;   // kind
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // predicted_class, best_score, zeros
	logic        m_tuser;   // all_impossible
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	histogram_naive_bayes_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// queues between stimulus, driver and checker
	beat_t    beats_to_send[$];
	verdict_t verdicts_due[$];
	int       beats_offered;
	int       mismatches;
	logic     quiet;        // no idling in the last stretch
	logic     long_hold_req;

	// shadow of the classifier state
	logic [4:0]  reg_classes;
	logic [6:0]  reg_features;
	logic [15:0] reg_train;
	logic [15:0] reg_smooth;
	logic [15:0] class_count [N_CLASSES];
	logic [7:0]  edge_count [N_FEATURES];
	logic signed [31:0] edge_val [N_FEATURES][EDGE_SLOTS];
	bit          edge_known [N_FEATURES][EDGE_SLOTS];
	logic [15:0] freq_tab [N_CLASSES][N_FEATURES][N_BINS];
	bit          freq_known [N_CLASSES][N_FEATURES][N_BINS];
	logic signed [31:0] class_score [N_CLASSES];
	bit          class_dead [N_CLASSES];
	int          position;

	// clock and cycle limit
	always begin
		clk = 1'b1; #10;
		clk = 1'b0; #10;
	end

	longint cycles;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("histogram_naive_bayes_classifier_test: done, errors");
			$finish;
		end
	end

	// log2 in Q16.16 by repeated squaring of the mantissa
	function automatic longint log2_q16(input longint unsigned n);
		int e;
		longint unsigned m;
		longint frac;
		if (n == 0) n = 1;
		e = 0;
		while (e < 30 && (n >> (e + 1)) != 0) e++;
		if (e <= 16) m = n << (16 - e);
		else m = n >> (e - 16);
		frac = 0;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 16;
			if (m >= 64'h20000) begin
				m = m >> 1;
				frac = frac | (longint'(1) << i);
			end
		end
		return (longint'(e) << 16) | frac;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int live_classes();
		if (reg_classes == 0) return 1;
		return (reg_classes > N_CLASSES) ? N_CLASSES : int'(reg_classes);
	endfunction

	function automatic int pattern_length();
		if (reg_features == 0) return 1;
		return (reg_features > N_FEATURES) ? N_FEATURES : int'(reg_features);
	endfunction

	// bin of a value for the feature at the current position
	function automatic int bin_of(input logic signed [31:0] v);
		int b;
		b = 0;
		for (int i = 0; i < edge_count[position]; i++)
			if (edge_val[position][i] <= v) b++;
		return b;
	endfunction

	// advance the shadow state by one beat and note any result it causes
	function automatic void score_beat(input beat_t it);
		int b;
		int winner;
		bit any;
		longint best;
		longint s;
		verdict_t v;
		case (it.kind)
			KIND_CLASS_COUNT: class_count[it.cls] = it.count;
			KIND_EDGE: if (it.bin < EDGE_SLOTS) begin
				edge_val[it.feat][it.bin] = it.value;
				edge_known[it.feat][it.bin] = 1;
			end
			KIND_FREQ: begin
				freq_tab[it.cls][it.feat][it.bin] = it.count;
				freq_known[it.cls][it.feat][it.bin] = 1;
			end
			KIND_EDGE_COUNT: edge_count[it.feat] = (it.count > EDGE_SLOTS) ? 8'(EDGE_SLOTS)
				: it.count[7:0];
			KIND_CLASSIFY: begin
				b = bin_of(it.value);
				for (int k = 0; k < live_classes(); k++) begin
					if (class_count[k] == 0) class_dead[k] = 1;
					else class_score[k] = clamp32(longint'(class_score[k])
						+ log2_q16(longint'(freq_tab[k][position][b]) + 1)
						- log2_q16(longint'(class_count[k]) + longint'(reg_smooth)));
				end
				if (!it.last && position + 1 < pattern_length()) begin
					position++;
				end else begin
					any = 0;
					winner = 0;
					best = -64'sd2147483648;
					for (int k = 0; k < live_classes(); k++) begin
						if (class_count[k] != 0 && !class_dead[k]) begin
							s = clamp32(longint'(class_score[k]) + log2_q16(class_count[k])
								- log2_q16(reg_train == 0 ? 1 : reg_train));
							// a later class takes a tie
							if (!any || s >= best) begin
								best = s;
								winner = k;
								any = 1;
							end
						end
					end
					v.cls = winner[3:0];
					v.score = any ? best[31:0] : 32'sh80000000;
					v.impossible = !any;
					verdicts_due = {verdicts_due, v};
					for (int k = 0; k < N_CLASSES; k++) begin
						class_score[k] = 0;
						class_dead[k] = 0;
					end
					position = 0;
				end
			end
			default: ;
		endcase
	endfunction

	task automatic offer(input logic [KIND_W-1:0] kind, input int cls, input int feat,
			input int bin, input logic signed [31:0] value, input int count, input bit last);
		beat_t it;
		it.kind = kind;
		it.cls = cls[3:0];
		it.feat = feat[5:0];
		it.bin = bin[7:0];
		it.value = value;
		it.count = count[15:0];
		it.last = last;
		score_beat(it);
		beats_to_send = {beats_to_send, it};
		beats_offered++;
		if (beats_offered > QUIET_AFTER) quiet = 1;
	endtask

	function automatic logic signed [31:0] edge_pick();
		if ($urandom_range(0, 7) == 0) return $urandom;
		return $signed($urandom_range(0, 4000)) - 2000;
	endfunction

	// a classify beat; tables it would read are filled first so no unwritten entry is read
	task automatic classify(input bit pick_near, input logic signed [31:0] raw, input bit last);
		logic signed [31:0] v;
		int b;
		for (int i = 0; i < edge_count[position]; i++)
			if (!edge_known[position][i]) offer(KIND_EDGE, 0, position, i, edge_pick(), 0, 0);
		v = raw;
		if (pick_near && edge_count[position] > 0)
			v = edge_val[position][$urandom_range(0, edge_count[position] - 1)]
				+ $signed($urandom_range(0, 2)) - 1;
		b = bin_of(v);
		for (int k = 0; k < live_classes(); k++)
			if (class_count[k] != 0 && !freq_known[k][position][b])
				offer(KIND_FREQ, k, position, b, 0,
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 60), 0);
		offer(KIND_CLASSIFY, 0, 0, 0, v, 0, last);
	endtask

	// wait until the block has drained everything it was given
	task automatic settle();
		while (!(beats_to_send.size() == 0 && !s_tvalid && verdicts_due.size() == 0))
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input int data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[15:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_NUM_CLASSES:  reg_classes = data[4:0];
			CFG_NUM_FEATURES: reg_features = data[6:0];
			CFG_TRAIN_COUNT:  reg_train = data[15:0];
			CFG_SMOOTHING:    reg_smooth = data[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// noise beats: ignored kinds, dropped edge slot, rewrites of any table
	task automatic noise();
		case ($urandom_range(0, 5))
			0: offer(KIND_W'(KIND_RESERVED + $urandom_range(0, 2)), $urandom_range(0, 15),
				$urandom_range(0, 63), $urandom_range(0, 255), $urandom, $urandom_range(0, 65535),
				$urandom_range(0, 1));
			1: offer(KIND_EDGE, $urandom_range(0, 15), $urandom_range(0, 63), EDGE_SLOTS,
				$urandom, 0, 0);
			2: offer(KIND_EDGE, 0, $urandom_range(0, 63), $urandom_range(0, 8), edge_pick(), 0, 0);
			3: offer(KIND_FREQ, $urandom_range(0, 15), $urandom_range(0, 63), $urandom_range(0, 255),
				$urandom, $urandom_range(0, 65535), 0);
			4: offer(KIND_EDGE_COUNT, 0, $urandom_range(0, 63), 0, 0, $urandom_range(0, 6), 0);
			default: offer(KIND_CLASS_COUNT, $urandom_range(0, 15), 0, 0, 0,
				$urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 300), 0);
		endcase
	endtask

	// stimulus
	initial begin
		int nc, nf, tc, se, phase, patterns;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		long_hold_req = 0;
		beats_offered = 0;
		mismatches = 0;
		cycles = 0;
		reg_classes = 2;
		reg_features = 1;
		reg_train = 1;
		reg_smooth = 0;
		position = 0;
		for (int k = 0; k < N_CLASSES; k++) begin
			class_count[k] = 0;
			class_score[k] = 0;
			class_dead[k] = 0;
		end
		for (int f = 0; f < N_FEATURES; f++) edge_count[f] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, ignored beats, unsorted edges, tie, no live class
		write_reg(CFG_NUM_CLASSES, 2);
		write_reg(CFG_NUM_FEATURES, 3);
		write_reg(CFG_TRAIN_COUNT, 65535);
		write_reg(CFG_SMOOTHING, 0);
		offer(KIND_CLASS_COUNT, 0, 0, 0, 0, 65535, 0);
		offer(KIND_CLASS_COUNT, 1, 0, 0, 0, 1, 0);
		offer(KIND_CLASS_COUNT, 15, 0, 0, 0, 0, 0);
		offer(KIND_EDGE_COUNT, 0, 63, 0, 0, 65535, 0);    // saturates
		offer(KIND_EDGE_COUNT, 0, 63, 0, 0, 0, 0);
		offer(KIND_EDGE, 15, 63, EDGE_SLOTS, 32'sh7fffffff, 0, 0);   // slot past the table
		offer(KIND_FREQ, 15, 63, 255, 32'sh80000000, 65535, 1);
		offer(KIND_W'(KIND_RESERVED + 2), 15, 63, 255, -1, 65535, 1);
		offer(KIND_RESERVED, 0, 0, 0, 0, 0, 0);
		offer(KIND_EDGE_COUNT, 0, 0, 0, 0, 2, 0);
		offer(KIND_EDGE, 0, 0, 0, 100, 0, 0);
		offer(KIND_EDGE, 0, 0, 1, -50, 0, 0);             // unsorted
		classify(0, 32'sh80000000, 0);
		classify(0, 32'sh7fffffff, 0);
		classify(0, 75, 0);                                // ends at the pattern length
		offer(KIND_CLASS_COUNT, 0, 0, 0, 0, 4, 0);
		offer(KIND_CLASS_COUNT, 1, 0, 0, 0, 4, 0);
		offer(KIND_FREQ, 0, 0, 0, 0, 7, 0);
		offer(KIND_FREQ, 1, 0, 0, 0, 7, 0);
		classify(0, 32'sh80000000, 1);                     // tie, class 1 wins
		offer(KIND_CLASS_COUNT, 0, 0, 0, 0, 0, 0);
		offer(KIND_CLASS_COUNT, 1, 0, 0, 0, 0, 0);
		classify(0, 0, 1);                                 // no live class
		settle();

		// random phases
		phase = 0;
		while (beats_offered < ITEM_TARGET) begin
			case (phase)
				0: begin nc = 16; nf = 4; tc = 65535; se = 65535; end
				1: begin nc = 0; nf = 0; tc = 0; se = 0; end
				2: begin nc = 31; nf = 2; tc = 1; se = 1; end
				3: begin nc = 2; nf = 127; tc = 100; se = 3; end
				4: begin nc = 1; nf = 64; tc = 7; se = 0; end
				default: begin
					nc = $urandom_range(0, 8) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 6);
					nf = $urandom_range(0, 6);
					tc = $urandom_range(0, 65535);
					se = $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 8);
				end
			endcase
			write_reg(CFG_NUM_CLASSES, nc);
			write_reg(CFG_NUM_FEATURES, nf);
			write_reg(CFG_TRAIN_COUNT, tc);
			write_reg(CFG_SMOOTHING, se);
			if (phase == 2) long_hold_req = 1;
			for (int k = 0; k < live_classes(); k++)
				offer(KIND_CLASS_COUNT, k, 0, 0, 0, $urandom_range(0, 6) == 0 ? 0
					: ($urandom_range(0, 9) == 0 ? 65535 : $urandom_range(1, 300)), 0);
			for (int f = 0; f < pattern_length(); f++)
				if ($urandom_range(0, 1)) offer(KIND_EDGE_COUNT, 0, f, 0, 0, $urandom_range(0, 5), 0);
			patterns = (pattern_length() > 8) ? 2 : $urandom_range(6, 14);
			for (int p = 0; p < patterns; p++) begin
				do begin
					if ($urandom_range(0, 9) == 0) noise();
					classify($urandom_range(0, 9) < 7, $urandom, $urandom_range(0, 9) == 0);
				end while (position != 0);
			end
			// sender pauses until every result is back
			settle();
			phase++;
		end

		settle();
		if (mismatches == 0) $display("histogram_naive_bayes_classifier_test: done, clean");
		else $display("histogram_naive_bayes_classifier_test: done, errors");
		$finish;
	end

	// input driver: one beat per handshake, random bursts of gaps
	logic s_fire;
	int   send_gap;
	always @(posedge clk) s_fire <= s_tvalid && s_tready;

	always @(negedge clk) begin
		beat_t it;
		if (!arst_n) begin
			send_gap <= 0;
		end else if (s_tvalid && !s_fire) begin
			// beat still waiting
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (beats_to_send.size() > 0) begin
			if (!quiet && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 1'b0;
				send_gap <= $urandom_range(0, 5);
			end else begin
				it = beats_to_send.pop_front();
				s_tdata <= {6'd0, it.count, it.value, it.bin, it.feat, it.cls};
				s_tuser <= it.kind;
				s_tlast <= it.last;
				s_tvalid <= 1'b1;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// result ready: random stall bursts, one long hold-off so the input backs up
	int hold_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			hold_left <= 0;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (long_hold_req) begin
			m_tready <= 1'b0;
			hold_left <= LONG_HOLD;
			long_hold_req <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			hold_left <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected result: predicted_class %0d", m_tdata[3:0]);
				mismatches++;
			end else begin
				want = verdicts_due.pop_front();
				if (m_tdata[3:0] !== want.cls) begin
					$error("predicted_class: expected %0d, got %0d", want.cls, m_tdata[3:0]);
					mismatches++;
				end
				if ($signed(m_tdata[35:4]) !== want.score) begin
					$error("best_score: expected %0d, got %0d", want.score, $signed(m_tdata[35:4]));
					mismatches++;
				end
				if (m_tuser !== want.impossible) begin
					$error("all_impossible: expected %0d, got %0d", want.impossible, m_tuser);
					mismatches++;
				end
			end
		end
	end

endmodule
